[sv/dac_pkg.sv]
// Shared types and constants of the door access controller.
`default_nettype none
package dac_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;

  localparam logic [2:0] ReqTick = 3'd0;
  localparam logic [2:0] ReqKey = 3'd1;
  localparam logic [2:0] ReqCard = 3'd2;
  localparam logic [2:0] ReqExit = 3'd3;
  localparam logic [2:0] ReqAdd = 3'd4;
  localparam logic [2:0] ReqDel = 3'd5;
  localparam logic [2:0] ReqGet = 3'd6;

  localparam logic [CfgIdxW-1:0] CfgEntryTimeout = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDenyTime = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDenyBeep = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOpenTime = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMinDigits = 3'd4;

  localparam logic [2:0] EvNone = 3'd0;
  localparam logic [2:0] EvDeny = 3'd1;
  localparam logic [2:0] EvLocked = 3'd2;
  localparam logic [2:0] EvUnlock = 3'd3;
  localparam logic [2:0] EvExit = 3'd4;
  localparam logic [2:0] EvKey = 3'd5;
  localparam logic [2:0] EvCard = 3'd6;
  localparam logic [2:0] EvKeyDeny = 3'd7;

  localparam logic [1:0] StNone = 2'd0;
  localparam logic [1:0] StAck = 2'd1;
  localparam logic [1:0] StStale = 2'd2;
  localparam logic [1:0] StFail = 2'd3;

  localparam logic [31:0] EmptyWord = 32'hffff_ffff;
  localparam logic [15:0] SeqUnset = 16'hffff;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0, ModeActive = 2'd1, ModeOpen = 2'd2, ModeDeny = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] key_code;
    logic [31:0] card_value;
    logic [31:0] entry_hash;
    logic [15:0] req_seq;
  } req_t;

  typedef struct packed {
    logic relay_on;
    logic card_led;
    logic keypad_led;
    logic card_beep;
    logic keypad_beep;
    logic [2:0] log_event;
    logic [31:0] log_value;
    logic [1:0] reply_status;
    logic [15:0] reply_seq;
  } rsp_t;
endpackage
`default_nettype wire

[sv/dac_if.sv]
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface dac_req_if;
  logic valid;
  logic ready;
  dac_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dac_rsp_if;
  logic valid;
  logic ready;
  dac_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/door_access_controller.sv]
// Top level of the door access controller with its key table scanner.
// Usage: requests arrive as words on req (tick, key, card, exit, add, delete,
// get state); each request yields exactly one response word on rsp.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while the block is idle; nothing enforces it.
// Tick, card, exit, get state and short keys go straight from execute to the
// response state. A key that searches, an add or a delete scans the key table
// memory one slot a cycle, stopping at the first hit or after the last slot.
// The rate is set by the single read port of the key table memory.
// After reset a clearing pass writes the empty word to every slot; no request
// is accepted during the pass.
// One request is in work at a time; a response that waits in the output
// register while the receiver stalls holds the block, the next request is
// taken once the response is accepted.
`default_nettype none
module door_access_controller #(
  parameter int unsigned KEY_SLOTS = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [dac_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dac_pkg::CfgDataW-1:0] cfg_data_i,
  dac_req_if.sink req,
  dac_rsp_if.source rsp
);
  localparam int unsigned AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [AW:0] LastSlot = (AW+1)'(KEY_SLOTS - 1);

  typedef enum logic [5:0] {
    SClear = 6'b000001, SIdle = 6'b000010, SExec = 6'b000100,
    SScan = 6'b001000, SDone = 6'b010000, SResp = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mem [KEY_SLOTS];
  logic [31:0] rd_q;
  logic [AW:0] addr_q, addr_d;
  logic we;
  logic [AW-1:0] wa;
  logic [31:0] wd;
  logic rd_v_q;
  logic [AW-1:0] rd_a_q;

  logic [10:0] to_q, dt_q, db_q, ot_q;
  logic [3:0] md_q;
  dac_pkg::mode_e mode_q, mode_d;
  logic [11:0] tick_q, tick_d;
  logic [3:0] dig_q, dig_d;
  logic [31:0] pin_q, pin_d, card_q, card_d;
  logic [15:0] seq_q, seq_d;
  logic [4:0] lamp_q, lamp_d;
  dac_pkg::req_t r_q;
  logic [31:0] target_q, target_d;
  logic [2:0] ev_q, ev_d;
  logic [31:0] val_q, val_d;
  logic [1:0] st_q, st_d;
  logic [15:0] rs_q, rs_d;
  logic [31:0] hash;
  logic [31:0] pin_next;
  logic stale;
  logic hit;
  logic rsp_v_q;

  assign pin_next = 32'(pin_q * 32'd10) + {28'd0, r_q.key_code};
  assign hash = card_q ^ {pin_next[15:0], pin_next[31:16]};
  assign stale = (seq_q != dac_pkg::SeqUnset) && (seq_q > r_q.req_seq);
  assign hit = rd_v_q && (rd_q == target_q);

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_q <= 11'd500; dt_q <= 11'd200; db_q <= 11'd100; ot_q <= 11'd1000;
      md_q <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dac_pkg::CfgEntryTimeout: to_q <= cfg_data_i;
        dac_pkg::CfgDenyTime: dt_q <= cfg_data_i;
        dac_pkg::CfgDenyBeep: db_q <= cfg_data_i;
        dac_pkg::CfgOpenTime: ot_q <= cfg_data_i;
        dac_pkg::CfgMinDigits: md_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; addr_q <= '0; rd_v_q <= 1'b0; rd_a_q <= '0;
      mode_q <= dac_pkg::ModeIdle; tick_q <= '0; dig_q <= '0; pin_q <= '0;
      card_q <= '0; seq_q <= dac_pkg::SeqUnset; lamp_q <= '0; rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d; addr_q <= addr_d;
      rd_v_q <= (state_q == SScan) && (addr_q <= LastSlot);
      rd_a_q <= addr_q[AW-1:0];
      mode_q <= mode_d; tick_q <= tick_d; dig_q <= dig_d; pin_q <= pin_d;
      card_q <= card_d; seq_q <= seq_d; lamp_q <= lamp_d;
      rsp_v_q <= (state_d == SResp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) r_q <= req.data;
    target_q <= target_d; ev_q <= ev_d; val_q <= val_d; st_q <= st_d; rs_q <= rs_d;
  end

  always_comb begin
    state_d = state_q; addr_d = addr_q; we = 1'b0; wa = addr_q[AW-1:0];
    wd = dac_pkg::EmptyWord;
    mode_d = mode_q; tick_d = tick_q; dig_d = dig_q; pin_d = pin_q;
    card_d = card_q; seq_d = seq_q; lamp_d = lamp_q;
    target_d = target_q; ev_d = ev_q; val_d = val_q; st_d = st_q; rs_d = rs_q;
    unique case (state_q)
      SClear: begin
        we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LastSlot) state_d = SIdle;
      end
      SIdle: begin
        if (req.valid) state_d = SExec;
      end
      SExec: begin
        ev_d = dac_pkg::EvNone; val_d = '0; st_d = dac_pkg::StNone; rs_d = '0;
        addr_d = '0;
        state_d = SResp;
        unique case (r_q.req_type)
          dac_pkg::ReqTick: begin
            if (mode_q != dac_pkg::ModeIdle) tick_d = tick_q + 1'b1;
            if (mode_q == dac_pkg::ModeActive) begin
              lamp_d[2] = tick_d[6];
              if (tick_d > {1'b0, to_q}) begin
                lamp_d[2] = 1'b0; ev_d = dac_pkg::EvDeny;
                mode_d = dac_pkg::ModeDeny; tick_d = '0;
              end
            end else if (mode_q == dac_pkg::ModeDeny) begin
              lamp_d[3] = tick_d > {1'b0, db_q};
              lamp_d[4] = 1'b1; lamp_d[1] = 1'b0; lamp_d[2] = 1'b0;
              if (tick_d > {1'b0, dt_q}) begin
                lamp_d[3] = 1'b0; lamp_d[4] = 1'b0; mode_d = dac_pkg::ModeIdle;
              end
            end else if (mode_q == dac_pkg::ModeOpen) begin
              lamp_d[2:0] = 3'b111;
              if (tick_d > {1'b0, ot_q}) begin
                ev_d = dac_pkg::EvLocked; lamp_d[2:0] = 3'b000;
                mode_d = dac_pkg::ModeIdle;
              end
            end
          end
          dac_pkg::ReqKey: begin
            ev_d = dac_pkg::EvKey; val_d = {28'd0, r_q.key_code};
            if (mode_q == dac_pkg::ModeActive) begin
              tick_d = '0;
              if (r_q.key_code <= 4'd9) begin
                if (dig_q > 4'd8) begin
                  mode_d = dac_pkg::ModeDeny; ev_d = dac_pkg::EvKeyDeny;
                end else begin
                  dig_d = dig_q + 1'b1; pin_d = pin_next;
                  if (dig_d >= md_q && hash != dac_pkg::EmptyWord) begin
                    target_d = hash; state_d = SScan;
                  end
                end
              end
            end
          end
          dac_pkg::ReqCard: begin
            ev_d = dac_pkg::EvCard; val_d = r_q.card_value;
            mode_d = dac_pkg::ModeActive; lamp_d[4:3] = 2'b00;
            pin_d = '0; tick_d = '0; dig_d = '0; card_d = r_q.card_value;
            lamp_d[1] = 1'b1;
          end
          dac_pkg::ReqExit: begin
            ev_d = dac_pkg::EvExit; tick_d = '0; mode_d = dac_pkg::ModeOpen;
          end
          dac_pkg::ReqAdd, dac_pkg::ReqDel: begin
            rs_d = r_q.req_seq;
            if (stale) st_d = dac_pkg::StStale;
            else if (r_q.entry_hash == dac_pkg::EmptyWord) st_d = dac_pkg::StFail;
            else begin
              st_d = dac_pkg::StFail; state_d = SScan;
              target_d = (r_q.req_type == dac_pkg::ReqAdd) ? dac_pkg::EmptyWord
                                                           : r_q.entry_hash;
            end
          end
          dac_pkg::ReqGet: begin
            st_d = dac_pkg::StAck; rs_d = seq_q;
          end
          default: ;
        endcase
      end
      SScan: begin
        if (hit) begin
          state_d = SResp;
          if (r_q.req_type == dac_pkg::ReqKey) begin
            ev_d = dac_pkg::EvUnlock; val_d = target_q; tick_d = '0;
            mode_d = dac_pkg::ModeOpen;
          end else begin
            we = 1'b1; wa = rd_a_q; st_d = dac_pkg::StAck; seq_d = r_q.req_seq;
            wd = (r_q.req_type == dac_pkg::ReqAdd) ? r_q.entry_hash
                                                   : dac_pkg::EmptyWord;
          end
        end else if (addr_q > LastSlot && !rd_v_q) begin
          state_d = SResp;
        end else if (addr_q <= LastSlot) begin
          addr_d = addr_q + 1'b1;
        end
      end
      SResp: begin
        if (rsp.ready && rsp_v_q) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = rsp_v_q && (state_q == SResp);
  assign rsp.data = '{relay_on: lamp_q[0], card_led: lamp_q[1], keypad_led: lamp_q[2],
                      card_beep: lamp_q[3], keypad_beep: lamp_q[4], log_event: ev_q,
                      log_value: val_q, reply_status: st_q, reply_seq: rs_q};
endmodule
`default_nettype wire

[sv/dac_checker.sv]
// Port-level assertions of the door access controller and their bind.
`default_nettype none
module dac_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [1:0] reply_status,
  input wire logic [15:0] reply_seq
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken with response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
  a_quiet_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && reply_status == dac_pkg::StNone |-> reply_seq == 16'd0)
    else $error("sequence without reply");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_ready |=> !rsp_valid) else $error("response repeated");
endmodule

bind door_access_controller dac_checker u_dac_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .reply_status(rsp.data.reply_status), .reply_seq(rsp.data.reply_seq));
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the door access controller: directed table, random sessions.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 256;
  localparam int unsigned WatchLimit = 6000;

  typedef struct {
    dac_pkg::req_t  word;
    bit             typed;
    dac_pkg::rsp_t  want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [dac_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [dac_pkg::CfgDataW-1:0] cfg_data_i;

  dac_req_if req_if ();
  dac_rsp_if rsp_if ();

  door_access_controller #(.KEY_SLOTS(Slots)) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req(req_if),
    .rsp(rsp_if)
  );

  // shadow of the block
  logic [10:0] entry_timeout, deny_time, deny_beep_after, open_time;
  logic [3:0]  min_digits;
  dac_pkg::mode_e mode;
  logic [11:0] ticks;
  logic [3:0]  digits;
  logic [31:0] pin, card;
  logic [31:0] key_table [Slots];
  logic [15:0] table_seq;
  logic        relay, card_led, key_led, card_beep, key_beep;

  dac_pkg::rsp_t pending_rsp[$];
  int    src_idle, snk_idle;
  bit    failed;
  int    quiet;
  int    sent;
  logic [15:0] next_seq;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic dac_pkg::req_t mk_req(logic [2:0] t, logic [3:0] k, logic [31:0] c,
                                           logic [31:0] h, logic [15:0] s);
    dac_pkg::req_t r;
    r.req_type = t;
    r.key_code = k;
    r.card_value = c;
    r.entry_hash = h;
    r.req_seq = s;
    return r;
  endfunction

  function automatic dac_pkg::rsp_t mk_rsp(logic [4:0] lamps, logic [2:0] ev,
                                           logic [31:0] val, logic [1:0] st,
                                           logic [15:0] s);
    dac_pkg::rsp_t r;
    {r.relay_on, r.card_led, r.keypad_led, r.card_beep, r.keypad_beep} = lamps;
    r.log_event = ev;
    r.log_value = val;
    r.reply_status = st;
    r.reply_seq = s;
    return r;
  endfunction

  function automatic logic [31:0] unlock_hash(logic [31:0] c, logic [31:0] p);
    return c ^ {p[15:0], p[31:16]};
  endfunction

  function automatic bit table_has(logic [31:0] w);
    if (w == dac_pkg::EmptyWord) return 1'b0;
    foreach (key_table[i]) if (key_table[i] == w) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit seq_stale(logic [15:0] s);
    return table_seq != dac_pkg::SeqUnset && table_seq > s;
  endfunction

  task automatic reset_shadow();
    entry_timeout = 11'd500;
    deny_time = 11'd200;
    deny_beep_after = 11'd100;
    open_time = 11'd1000;
    min_digits = 4'd4;
    mode = dac_pkg::ModeIdle;
    ticks = '0;
    digits = '0;
    pin = '0;
    card = '0;
    foreach (key_table[i]) key_table[i] = dac_pkg::EmptyWord;
    table_seq = dac_pkg::SeqUnset;
    {relay, card_led, key_led, card_beep, key_beep} = '0;
  endtask

  task automatic step_door(input dac_pkg::req_t w, output dac_pkg::rsp_t r);
    logic [2:0]  ev;
    logic [31:0] val;
    logic [1:0]  st;
    logic [15:0] rs;
    logic [31:0] h;
    bit          done;
    ev = dac_pkg::EvNone;
    val = '0;
    st = dac_pkg::StNone;
    rs = '0;
    case (w.req_type)
      dac_pkg::ReqTick: begin
        if (mode == dac_pkg::ModeActive) begin
          ticks = ticks + 12'd1;
          key_led = ticks[6];
          if (ticks > entry_timeout) begin
            key_led = 1'b0;
            ev = dac_pkg::EvDeny;
            mode = dac_pkg::ModeDeny;
            ticks = '0;
          end
        end else if (mode == dac_pkg::ModeDeny) begin
          ticks = ticks + 12'd1;
          card_beep = ticks > deny_beep_after;
          key_beep = 1'b1;
          card_led = 1'b0;
          key_led = 1'b0;
          if (ticks > deny_time) begin
            card_beep = 1'b0;
            key_beep = 1'b0;
            mode = dac_pkg::ModeIdle;
          end
        end else if (mode == dac_pkg::ModeOpen) begin
          ticks = ticks + 12'd1;
          {card_led, key_led, relay} = 3'b111;
          if (ticks > open_time) begin
            ev = dac_pkg::EvLocked;
            {card_led, key_led, relay} = 3'b000;
            mode = dac_pkg::ModeIdle;
          end
        end
      end
      dac_pkg::ReqKey: begin
        ev = dac_pkg::EvKey;
        val = 32'(w.key_code);
        if (mode == dac_pkg::ModeActive) begin
          ticks = '0;
          if (w.key_code <= 4'd9) begin
            if (digits > 4'd8) begin
              mode = dac_pkg::ModeDeny;
              ev = dac_pkg::EvKeyDeny;
            end else begin
              digits = digits + 4'd1;
              pin = pin * 32'd10 + 32'(w.key_code);
              if (digits >= min_digits) begin
                h = unlock_hash(card, pin);
                if (table_has(h)) begin
                  ev = dac_pkg::EvUnlock;
                  val = h;
                  ticks = '0;
                  mode = dac_pkg::ModeOpen;
                end
              end
            end
          end
        end
      end
      dac_pkg::ReqCard: begin
        ev = dac_pkg::EvCard;
        val = w.card_value;
        mode = dac_pkg::ModeActive;
        card_beep = 1'b0;
        key_beep = 1'b0;
        pin = '0;
        ticks = '0;
        digits = '0;
        card = w.card_value;
        card_led = 1'b1;
      end
      dac_pkg::ReqExit: begin
        ev = dac_pkg::EvExit;
        ticks = '0;
        mode = dac_pkg::ModeOpen;
      end
      dac_pkg::ReqAdd, dac_pkg::ReqDel: begin
        rs = w.req_seq;
        done = 1'b0;
        if (seq_stale(w.req_seq)) st = dac_pkg::StStale;
        else if (w.entry_hash == dac_pkg::EmptyWord) st = dac_pkg::StFail;
        else begin
          st = dac_pkg::StFail;
          foreach (key_table[i]) begin
            if (!done && w.req_type == dac_pkg::ReqAdd &&
                key_table[i] == dac_pkg::EmptyWord) begin
              key_table[i] = w.entry_hash;
              done = 1'b1;
            end else if (!done && w.req_type == dac_pkg::ReqDel &&
                         key_table[i] == w.entry_hash) begin
              key_table[i] = dac_pkg::EmptyWord;
              done = 1'b1;
            end
          end
          if (done) begin
            st = dac_pkg::StAck;
            table_seq = w.req_seq;
          end
        end
      end
      dac_pkg::ReqGet: begin
        st = dac_pkg::StAck;
        rs = table_seq;
      end
      default: ;
    endcase
    r = mk_rsp({relay, card_led, key_led, card_beep, key_beep}, ev, val, st, rs);
  endtask

  task automatic send_word(input dac_pkg::req_t w, input bit typed = 1'b0,
                           input dac_pkg::rsp_t want = '0);
    dac_pkg::rsp_t r;
    step_door(w, r);
    pending_rsp.push_back(typed ? want : r);
    sent++;
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= w;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [dac_pkg::CfgIdxW-1:0] idx, logic [10:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dac_pkg::CfgEntryTimeout: entry_timeout = v;
      dac_pkg::CfgDenyTime: deny_time = v;
      dac_pkg::CfgDenyBeep: deny_beep_after = v;
      dac_pkg::CfgOpenTime: open_time = v;
      dac_pkg::CfgMinDigits: min_digits = v[3:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [10:0] et, logic [10:0] dt, logic [10:0] db,
                            logic [10:0] ot, logic [3:0] md);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (Slots + 10) @(negedge clk_i);
    write_reg(dac_pkg::CfgEntryTimeout, et);
    write_reg(dac_pkg::CfgDenyTime, dt);
    write_reg(dac_pkg::CfgDenyBeep, db);
    write_reg(dac_pkg::CfgOpenTime, ot);
    write_reg(dac_pkg::CfgMinDigits, 11'(md));
  endtask

  function automatic logic [15:0] take_seq();
    next_seq = ($urandom_range(9) == 0) ? 16'($urandom) : next_seq + 16'($urandom_range(3));
    return next_seq;
  endfunction

  task automatic random_word();
    logic [2:0] t;
    t = 3'($urandom_range(7));
    send_word(mk_req(t, 4'($urandom), $urandom, $urandom, take_seq()));
  endtask

  task automatic tick_burst(int n);
    repeat (n) send_word(mk_req(dac_pkg::ReqTick, 4'($urandom), $urandom, $urandom,
                                16'($urandom)));
  endtask

  // one card-and-PIN attempt, mostly with a credential that is in the table
  task automatic session(int max_ticks);
    int          n;
    logic [3:0]  d [10];
    logic [31:0] p, c;
    n = ($urandom_range(9) == 0) ? 10 : $urandom_range(1, 9);
    p = '0;
    for (int i = 0; i < n; i++) begin
      d[i] = 4'($urandom_range(9));
      p = p * 10 + 32'(d[i]);
    end
    c = $urandom;
    if ($urandom_range(3) != 0)
      send_word(mk_req(dac_pkg::ReqAdd, 4'($urandom), $urandom, unlock_hash(c, p),
                       take_seq()));
    send_word(mk_req(dac_pkg::ReqCard, 4'($urandom), c, $urandom, 16'($urandom)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) tick_burst($urandom_range(1, 3));
      if ($urandom_range(11) == 0)
        send_word(mk_req(dac_pkg::ReqKey, 4'($urandom_range(10, 15)), $urandom, $urandom,
                         16'($urandom)));
      send_word(mk_req(dac_pkg::ReqKey, d[i], $urandom, $urandom, 16'($urandom)));
    end
    if ($urandom_range(2) == 0)
      send_word(mk_req(dac_pkg::ReqGet, '0, $urandom, $urandom, 16'($urandom)));
    if ($urandom_range(3) == 0)
      send_word(mk_req(dac_pkg::ReqDel, 4'($urandom), $urandom, unlock_hash(c, p),
                       take_seq()));
    tick_burst($urandom_range(0, max_ticks));
  endtask

  task automatic random_phase(int n_items, int max_ticks);
    int stop;
    stop = sent + n_items;
    while (sent < stop) begin
      if ($urandom_range(9) < 6) session(max_ticks);
      else random_word();
    end
  endtask

  // receiver
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // response checker and watchdog
  always @(posedge clk_i) begin
    dac_pkg::rsp_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response word %h", got);
        failed = 1'b1;
      end else begin
        want = pending_rsp.pop_front();
        if (got.relay_on !== want.relay_on) begin
          $error("relay_on: expected %0d, got %0d", want.relay_on, got.relay_on);
          failed = 1'b1;
        end
        if (got.card_led !== want.card_led) begin
          $error("card_led: expected %0d, got %0d", want.card_led, got.card_led);
          failed = 1'b1;
        end
        if (got.keypad_led !== want.keypad_led) begin
          $error("keypad_led: expected %0d, got %0d", want.keypad_led, got.keypad_led);
          failed = 1'b1;
        end
        if (got.card_beep !== want.card_beep) begin
          $error("card_beep: expected %0d, got %0d", want.card_beep, got.card_beep);
          failed = 1'b1;
        end
        if (got.keypad_beep !== want.keypad_beep) begin
          $error("keypad_beep: expected %0d, got %0d", want.keypad_beep, got.keypad_beep);
          failed = 1'b1;
        end
        if (got.log_event !== want.log_event) begin
          $error("log_event: expected %0d, got %0d", want.log_event, got.log_event);
          failed = 1'b1;
        end
        if (got.log_value !== want.log_value) begin
          $error("log_value: expected %h, got %h", want.log_value, got.log_value);
          failed = 1'b1;
        end
        if (got.reply_status !== want.reply_status) begin
          $error("reply_status: expected %0d, got %0d", want.reply_status, got.reply_status);
          failed = 1'b1;
        end
        if (got.reply_seq !== want.reply_seq) begin
          $error("reply_seq: expected %h, got %h", want.reply_seq, got.reply_seq);
          failed = 1'b1;
        end
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchLimit) begin
      $display("door_access_controller regression: fail");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    logic [31:0] cred;
    failed = 1'b0;
    quiet = 0;
    sent = 0;
    next_seq = 16'd20;
    src_idle = 28;
    snk_idle = 88;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    reset_shadow();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cred = unlock_hash(32'hdead_beef, 32'd1234);
    rows = '{
      '{mk_req(dac_pkg::ReqGet, 4'd0, 32'd0, 32'd0, 16'd0), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StAck, dac_pkg::SeqUnset)},
      '{mk_req(dac_pkg::ReqKey, 4'd11, 32'd0, 32'd0, 16'd0), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvKey, 32'd11, dac_pkg::StNone, 16'd0)},
      '{mk_req(dac_pkg::ReqAdd, 4'd0, 32'd0, dac_pkg::EmptyWord, 16'd5), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StFail, 16'd5)},
      '{mk_req(dac_pkg::ReqDel, 4'd0, 32'd0, 32'h1234, 16'd3), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StFail, 16'd3)},
      '{mk_req(dac_pkg::ReqAdd, 4'd0, 32'd0, cred, 16'd10), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StAck, 16'd10)},
      '{mk_req(dac_pkg::ReqAdd, 4'd0, 32'd0, 32'h0, 16'd4), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StStale, 16'd4)},
      '{mk_req(dac_pkg::ReqGet, 4'd15, 32'd0, 32'd0, 16'hffff), 1'b1,
        mk_rsp(5'b0, dac_pkg::EvNone, 32'd0, dac_pkg::StAck, 16'd10)},
      '{mk_req(dac_pkg::ReqCard, 4'd0, 32'hdead_beef, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd1, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd10, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd2, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd3, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd4, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqTick, 4'd0, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(3'd7, 4'd15, dac_pkg::EmptyWord, dac_pkg::EmptyWord, 16'hffff), 1'b0, '0},
      '{mk_req(dac_pkg::ReqCard, 4'd0, dac_pkg::EmptyWord, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd12, 32'd0, 32'd0, 16'd0), 1'b0, '0},
      '{mk_req(dac_pkg::ReqKey, 4'd15, 32'd0, 32'd0, 16'd0), 1'b0, '0}
    };
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].want);
    repeat (10) send_word(mk_req(dac_pkg::ReqKey, 4'd9, 32'd0, 32'd0, 16'd0));
    send_word(mk_req(dac_pkg::ReqExit, 4'd0, 32'd0, 32'd0, 16'd0));
    send_word(mk_req(dac_pkg::ReqDel, 4'd0, 32'd0, cred, 16'd11));

    random_phase(150, 20);
    set_timing(11'd1, 11'd1, 11'd0, 11'd1, 4'd1);
    random_phase(260, 4);
    // fill the key table until it reports full, then drain part of it
    for (int i = 0; i < Slots + 4; i++)
      send_word(mk_req(dac_pkg::ReqAdd, 4'd0, 32'd0, $urandom, take_seq()));
    src_idle = 88;
    snk_idle = 28;
    set_timing(11'd80, 11'd70, 11'd65, 11'd70, 4'd9);
    random_phase(200, 90);
    repeat (60) send_word(mk_req(dac_pkg::ReqDel, 4'd0, 32'd0,
                                 key_table[$urandom_range(Slots - 1)], take_seq()));
    set_timing(11'd2047, 11'd2047, 11'd2047, 11'd2047, 4'd0);
    random_phase(200, 10);
    src_idle = 0;
    snk_idle = 0;
    set_timing(11'd12, 11'd9, 11'd4, 11'd7, 4'd15);
    random_phase(200, 16);
    set_timing(11'd10, 11'd6, 11'd3, 11'd5, 4'd3);
    random_phase(240, 14);

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (Slots + 10) @(negedge clk_i);
    if (!failed) begin
      $display("door_access_controller regression: pass");
    end else begin
      $display("door_access_controller regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
